>>> rtl/core/hwc_pkg.sv
package hwc_pkg;

  typedef struct packed {
    logic [31:0] version;
    logic [63:0] prev_hash_w0;
    logic [63:0] prev_hash_w1;
    logic [63:0] prev_hash_w2;
    logic [63:0] prev_hash_w3;
    logic [63:0] merkle_root_w0;
    logic [63:0] merkle_root_w1;
    logic [63:0] merkle_root_w2;
    logic [63:0] merkle_root_w3;
    logic [31:0] block_time;
    logic [31:0] target_bits;
    logic [31:0] nonce;
  } hdr_t;

  typedef struct packed {
    logic        meets_target;
    logic        target_overflow;
    logic [63:0] hash_w0;
    logic [63:0] hash_w1;
    logic [63:0] hash_w2;
    logic [63:0] hash_w3;
  } res_t;

  typedef logic [7:0][31:0]  state_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [3:0][31:0]  side_t;

  // one round cell's contents
  typedef struct packed {
    state_t st;
    block_t w;
    state_t hin;
    side_t  side;
  } round_t;

  localparam int unsigned Rounds = 64;

  localparam state_t Iv = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b0, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> rtl/core/hwc_cell.sv
module hwc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  hwc_pkg::round_t data_i,
  input  logic [31:0]     k_i,
  output logic            valid_o,
  output hwc_pkg::round_t data_o
);

  logic            valid_q;
  hwc_pkg::round_t data_q, data_d;
  logic [31:0]     t1, t2;

  always_comb begin
    t1 = data_i.st[7] + hwc_pkg::big_s1(data_i.st[4])
       + ((data_i.st[4] & data_i.st[5]) ^ (~data_i.st[4] & data_i.st[6]))
       + k_i + data_i.w[0];
    t2 = hwc_pkg::big_s0(data_i.st[0])
       + ((data_i.st[0] & data_i.st[1]) ^ (data_i.st[0] & data_i.st[2])
         ^ (data_i.st[1] & data_i.st[2]));
    data_d       = data_i;
    data_d.st[0] = t1 + t2;
    data_d.st[1] = data_i.st[0];
    data_d.st[2] = data_i.st[1];
    data_d.st[3] = data_i.st[2];
    data_d.st[4] = data_i.st[3] + t1;
    data_d.st[5] = data_i.st[4];
    data_d.st[6] = data_i.st[5];
    data_d.st[7] = data_i.st[6];
    for (int i = 0; i < 15; i++) begin
      data_d.w[i] = data_i.w[i+1];
    end
    data_d.w[15] = data_i.w[0] + hwc_pkg::small_s0(data_i.w[1]) + data_i.w[9]
                 + hwc_pkg::small_s1(data_i.w[14]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/hwc_compress.sv
module hwc_compress (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  hwc_pkg::state_t st_i,
  input  hwc_pkg::block_t blk_i,
  input  hwc_pkg::side_t  side_i,
  output logic            valid_o,
  output hwc_pkg::state_t dig_o,
  output hwc_pkg::side_t  side_o
);

  logic            v [hwc_pkg::Rounds+1];
  hwc_pkg::round_t c [hwc_pkg::Rounds+1];
  logic            valid_q;
  hwc_pkg::state_t dig_q, dig_d;
  hwc_pkg::side_t  side_q;

  assign v[0]      = valid_i;
  assign c[0].st   = st_i;
  assign c[0].w    = blk_i;
  assign c[0].hin  = st_i;
  assign c[0].side = side_i;

  for (genvar i = 0; i < hwc_pkg::Rounds; i++) begin : g_cell
    hwc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[i]),
      .data_i  (c[i]),
      .k_i     (hwc_pkg::K[i]),
      .valid_o (v[i+1]),
      .data_o  (c[i+1])
    );
  end

  // feed-forward add
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dig_d[i] = c[hwc_pkg::Rounds].st[i] + c[hwc_pkg::Rounds].hin[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= v[hwc_pkg::Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    side_q <= c[hwc_pkg::Rounds].side;
  end

  assign valid_o = valid_q;
  assign dig_o   = dig_q;
  assign side_o  = side_q;

endmodule

>>> rtl/core/header_work_check_core.sv
// Fully pipelined double SHA-256 header check. A header is taken on any cycle
// with start_i high; busy_o is always low, so one header per clock is
// sustained. Three chains of 64 round cells (two blocks of the first hash,
// then the second hash), each followed by a feed-forward stage, plus a target
// expansion stage and a compare stage, lie between the transfer and the
// done_o strobe. Results leave in input order, one cycle each, and cannot
// be held off by the receiver.
module header_work_check_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  hwc_pkg::hdr_t data_i,
  output logic          busy_o,
  output logic          done_o,
  output hwc_pkg::res_t result_o
);

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  logic [19:0][31:0] hw;
  hwc_pkg::block_t   blk1, blk2, blk3;
  hwc_pkg::side_t    side0, side1, side2, side3;
  hwc_pkg::state_t   dig1, dig2, dig3;
  logic              v1, v2, v3;

  logic [63:0] prev [4];
  logic [63:0] mrk [4];

  assign prev[0] = data_i.prev_hash_w0;
  assign prev[1] = data_i.prev_hash_w1;
  assign prev[2] = data_i.prev_hash_w2;
  assign prev[3] = data_i.prev_hash_w3;
  assign mrk[0]  = data_i.merkle_root_w0;
  assign mrk[1]  = data_i.merkle_root_w1;
  assign mrk[2]  = data_i.merkle_root_w2;
  assign mrk[3]  = data_i.merkle_root_w3;

  // serialised header as big-endian message words
  always_comb begin
    hw[0] = bswap(data_i.version);
    for (int k = 0; k < 4; k++) begin
      hw[1+2*k]  = bswap(prev[k][31:0]);
      hw[2+2*k]  = bswap(prev[k][63:32]);
      hw[9+2*k]  = bswap(mrk[k][31:0]);
      hw[10+2*k] = bswap(mrk[k][63:32]);
    end
    hw[17] = bswap(data_i.block_time);
    hw[18] = bswap(data_i.target_bits);
    hw[19] = bswap(data_i.nonce);
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blk1[i] = hw[i];
    end
    for (int i = 0; i < 4; i++) begin
      side0[i] = hw[16+i];
    end
    blk2 = '0;
    for (int i = 0; i < 4; i++) begin
      blk2[i] = side1[i];
    end
    blk2[4]  = 32'h80000000;
    blk2[15] = 32'd640;
    blk3 = '0;
    for (int i = 0; i < 8; i++) begin
      blk3[i] = dig2[i];
    end
    blk3[8]  = 32'h80000000;
    blk3[15] = 32'd256;
  end

  hwc_compress u_comp1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .st_i    (hwc_pkg::Iv),
    .blk_i   (blk1),
    .side_i  (side0),
    .valid_o (v1),
    .dig_o   (dig1),
    .side_o  (side1)
  );

  hwc_compress u_comp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .st_i    (dig1),
    .blk_i   (blk2),
    .side_i  (side1),
    .valid_o (v2),
    .dig_o   (dig2),
    .side_o  (side2)
  );

  hwc_compress u_comp3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .st_i    (hwc_pkg::Iv),
    .blk_i   (blk3),
    .side_i  (side2),
    .valid_o (v3),
    .dig_o   (dig3),
    .side_o  (side3)
  );

  // target expansion
  logic [31:0]  tbits;
  logic [7:0]   ex;
  logic [22:0]  mant;
  logic [4:0]   mlen;
  logic [10:0]  sh;
  logic         ovf_d;
  logic [255:0] tgt_d, hash_d;

  always_comb begin
    tbits = bswap(side3[2]);
    ex    = tbits[31:24];
    mant  = tbits[22:0];
    mlen  = '0;
    for (int i = 0; i < 23; i++) begin
      if (mant[i]) begin
        mlen = 5'(i + 1);
      end
    end
    sh    = {ex, 3'b000} - 11'd24;
    ovf_d = (ex > 8'd3) && (mant != '0) && ((11'(mlen) + sh) > 11'd256);
    if (ex <= 8'd3) begin
      tgt_d = 256'(mant) >> {(2'd3 - ex[1:0]), 3'b000};
    end else if (ovf_d) begin
      tgt_d = '0;
    end else begin
      tgt_d = 256'(mant) << sh[7:0];
    end
    for (int i = 0; i < 4; i++) begin
      hash_d[64*i +: 32]      = bswap(dig3[2*i]);
      hash_d[64*i + 32 +: 32] = bswap(dig3[2*i+1]);
    end
  end

  logic         va_q, vb_q;
  logic         ovf_q;
  logic [255:0] tgt_q, hash_q;
  hwc_pkg::res_t res_q, res_d;

  always_comb begin
    res_d.target_overflow = ovf_q;
    res_d.meets_target    = !ovf_q && (hash_q <= tgt_q);
    res_d.hash_w0         = hash_q[63:0];
    res_d.hash_w1         = hash_q[127:64];
    res_d.hash_w2         = hash_q[191:128];
    res_d.hash_w3         = hash_q[255:192];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= v3;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q  <= ovf_d;
    tgt_q  <= tgt_d;
    hash_q <= hash_d;
    res_q  <= res_d;
  end

  assign busy_o   = 1'b0;
  assign done_o   = vb_q;
  assign result_o = res_q;

endmodule
